// ===== rtl/srws_pkg.sv =====
package srws_pkg;

  localparam int unsigned RING_DEPTH     = 64;
  localparam int unsigned WINDOW_SAMPLES = 20;

  localparam int unsigned AW   = $clog2(RING_DEPTH);
  localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned NW   = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned XW   = 16 + $clog2(WINDOW_SAMPLES);
  localparam int unsigned SXW  = XW + NW;
  localparam int unsigned SYW  = 16 + NW;
  localparam int unsigned SXXW = 2 * XW + NW;
  localparam int unsigned SXYW = XW + 16 + NW;
  localparam int unsigned P1W  = NW + SXXW;
  localparam int unsigned P2W  = 2 * SXW;
  localparam int unsigned P3W  = NW + 1 + SXYW;
  localparam int unsigned P4W  = SXW + 1 + SYW;
  localparam int unsigned DENW = ((P1W > P2W) ? P1W : P2W) + 1;
  localparam int unsigned NUMW = ((P3W > P4W) ? P3W : P4W) + 1;
  localparam int unsigned MAGW = NUMW;
  localparam int unsigned DVW  = MAGW + 16;
  localparam int unsigned RW   = DENW - 1;
  localparam int unsigned DCW  = $clog2(DVW + 1);

  localparam logic [15:0] SLOPE_SCALE = 16'd36000;

  localparam int unsigned WORD_W = 96;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_SLOPE = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_DETACHED   = 3'd0,
    CFG_INVALID    = 3'd1,
    CFG_WINDOW     = 3'd2,
    CFG_MAX_GAP    = 3'd3,
    CFG_MIN_POINTS = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_NEWEST,
    ST_WADDR,
    ST_WDATA,
    ST_MUL1,
    ST_MUL2,
    ST_SUB,
    ST_ABS,
    ST_SCALE,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] sample_time;
    logic [63:0] temps;
    logic [1:0]  probe_select;
    logic [5:0]  age_index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [15:0] detached_code;
    logic [15:0] invalid_code;
    logic [15:0] window_seconds;
    logic [15:0] max_gap_seconds;
    logic [4:0]  min_points;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_time;
    logic [63:0] temps;
    logic [31:0] slope;
    logic [6:0]  stored_count;
  } res_t;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] wp, logic [CW-1:0] age);
    logic [AW:0] s;
    s = (AW+1)'(wp) + (AW+1)'(RING_DEPTH - 1) - (AW+1)'(age);
    if (s >= (AW+1)'(RING_DEPTH)) begin
      s = s - (AW+1)'(RING_DEPTH);
    end
    return s[AW-1:0];
  endfunction

endpackage

// ===== rtl/srws_ram.sv =====
module srws_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/srws_front.sv =====
module srws_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [103:0]        s_axis_tdata_i,
  input  logic [1:0]          s_axis_tuser_i,
  output srws_pkg::q_head_t   head_o,
  input  logic                pop_i
);

  srws_pkg::cmd_t slot_q [2];
  srws_pkg::cmd_t in_cmd;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  always_comb begin
    in_cmd.op           = srws_pkg::op_e'(s_axis_tuser_i);
    in_cmd.sample_time  = s_axis_tdata_i[31:0];
    in_cmd.temps        = s_axis_tdata_i[95:32];
    in_cmd.probe_select = s_axis_tdata_i[97:96];
    in_cmd.age_index    = s_axis_tdata_i[103:98];
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= in_cmd;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_q];

endmodule

// ===== rtl/srws_back.sv =====
module srws_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srws_pkg::q_head_t head_i,
  output logic              pop_o,
  input  srws_pkg::cfg_t    cfg_i,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output srws_pkg::res_t    res_o
);

  localparam int unsigned AW   = srws_pkg::AW;
  localparam int unsigned CW   = srws_pkg::CW;
  localparam int unsigned NW   = srws_pkg::NW;
  localparam int unsigned XW   = srws_pkg::XW;
  localparam int unsigned SXW  = srws_pkg::SXW;
  localparam int unsigned SYW  = srws_pkg::SYW;
  localparam int unsigned SXXW = srws_pkg::SXXW;
  localparam int unsigned SXYW = srws_pkg::SXYW;
  localparam int unsigned P1W  = srws_pkg::P1W;
  localparam int unsigned P2W  = srws_pkg::P2W;
  localparam int unsigned P3W  = srws_pkg::P3W;
  localparam int unsigned P4W  = srws_pkg::P4W;
  localparam int unsigned DENW = srws_pkg::DENW;
  localparam int unsigned NUMW = srws_pkg::NUMW;
  localparam int unsigned MAGW = srws_pkg::MAGW;
  localparam int unsigned DVW  = srws_pkg::DVW;
  localparam int unsigned RW   = srws_pkg::RW;
  localparam int unsigned DCW  = srws_pkg::DCW;

  srws_pkg::back_state_e state_q, state_d;

  logic [AW-1:0]           wp_q, wp_d;
  logic [CW-1:0]           held_q, held_d;
  logic [NW-1:0]           k_q, k_d;
  logic [1:0]              probe_q, probe_d;
  logic [31:0]             wstart_q, wstart_d;
  logic [31:0]             prev_q, prev_d;
  logic                    got_first_q, got_first_d;
  logic [XW-1:0]           elapsed_q, elapsed_d;
  logic                    pend_q, pend_d;
  logic signed [15:0]      py_q, py_d;
  logic [NW-1:0]           n_q, n_d;
  logic [SXW-1:0]          sx_q, sx_d;
  logic signed [SYW-1:0]   sy_q, sy_d;
  logic [SXXW-1:0]         sxx_q, sxx_d;
  logic signed [SXYW-1:0]  sxy_q, sxy_d;
  logic [P1W-1:0]          p1_q, p1_d;
  logic [P2W-1:0]          p2_q, p2_d;
  logic signed [P3W-1:0]   p3_q, p3_d;
  logic signed [P4W-1:0]   p4_q, p4_d;
  logic signed [DENW-1:0]  den_q, den_d;
  logic signed [NUMW-1:0]  num_q, num_d;
  logic                    neg_q, neg_d;
  logic [MAGW-1:0]         mag_q, mag_d;
  logic [DVW-1:0]          dvd_q, dvd_d;
  logic [RW-1:0]           rem_q, rem_d;
  logic [DVW-1:0]          quo_q, quo_d;
  logic [DCW-1:0]          dcnt_q, dcnt_d;
  srws_pkg::res_t          res_q, res_d;
  srws_pkg::res_t          out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [srws_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  logic [31:0]             rd_time;
  logic [63:0]             rd_temps;
  logic [15:0]             code;
  logic [31:0]             gap;
  logic [2*XW-1:0]         xx;
  logic signed [XW+16:0]   xy;
  logic [RW:0]             sh;
  logic [31:0]             q_lo;

  srws_ram #(
    .WIDTH(srws_pkg::WORD_W),
    .DEPTH(srws_pkg::RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_time   = ram_rdata[31:0];
  assign rd_temps  = ram_rdata[95:32];
  assign ram_wdata = {head_i.cmd.temps, head_i.cmd.sample_time};

  always_comb begin
    unique case (probe_q)
      2'd0:    code = rd_temps[15:0];
      2'd1:    code = rd_temps[31:16];
      2'd2:    code = rd_temps[47:32];
      default: code = rd_temps[63:48];
    endcase
  end

  assign gap  = rd_time - prev_q;
  assign xx   = elapsed_q * elapsed_q;
  assign xy   = $signed({1'b0, elapsed_q}) * py_q;
  assign sh   = {rem_q, dvd_q[DVW-1]};
  assign q_lo = quo_q[31:0];

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    held_d      = held_q;
    k_d         = k_q;
    probe_d     = probe_q;
    wstart_d    = wstart_q;
    prev_d      = prev_q;
    got_first_d = got_first_q;
    elapsed_d   = elapsed_q;
    pend_d      = pend_q;
    py_d        = py_q;
    n_d         = n_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxx_d       = sxx_q;
    sxy_d       = sxy_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    p3_d        = p3_q;
    p4_d        = p4_q;
    den_d       = den_q;
    num_d       = num_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_tready_i;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      srws_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          res_d   = '0;
          probe_d = head_i.cmd.probe_select;
          unique case (head_i.cmd.op)
            srws_pkg::OP_PUSH: begin
              ram_we   = 1'b1;
              wp_d     = (wp_q == AW'(srws_pkg::RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
              if (held_q < CW'(srws_pkg::RING_DEPTH)) begin
                held_d = held_q + 1'b1;
              end
              res_d.ok = 1'b1;
              state_d  = srws_pkg::ST_DONE;
            end
            srws_pkg::OP_READ: begin
              if (32'(head_i.cmd.age_index) < 32'(held_q)) begin
                ram_raddr = srws_pkg::slot_of(wp_q, CW'(head_i.cmd.age_index));
                state_d   = srws_pkg::ST_READ;
              end else begin
                state_d = srws_pkg::ST_DONE;
              end
            end
            srws_pkg::OP_SLOPE: begin
              if (held_q == '0) begin
                state_d = srws_pkg::ST_DONE;
              end else begin
                ram_raddr = srws_pkg::slot_of(wp_q, '0);
                k_d = (32'(held_q) < 32'(srws_pkg::WINDOW_SAMPLES)) ?
                      NW'(held_q) : NW'(srws_pkg::WINDOW_SAMPLES);
                state_d = srws_pkg::ST_NEWEST;
              end
            end
            srws_pkg::OP_CLEAR: begin
              wp_d     = '0;
              held_d   = '0;
              res_d.ok = 1'b1;
              state_d  = srws_pkg::ST_DONE;
            end
            default: state_d = srws_pkg::ST_DONE;
          endcase
        end
      end
      srws_pkg::ST_READ: begin
        res_d.ok        = 1'b1;
        res_d.read_time = rd_time;
        res_d.temps     = rd_temps;
        state_d         = srws_pkg::ST_DONE;
      end
      srws_pkg::ST_NEWEST: begin
        wstart_d    = (rd_time >= 32'(cfg_i.window_seconds)) ?
                      rd_time - 32'(cfg_i.window_seconds) : '0;
        got_first_d = 1'b0;
        elapsed_d   = '0;
        pend_d      = 1'b0;
        n_d         = '0;
        sx_d        = '0;
        sy_d        = '0;
        sxx_d       = '0;
        sxy_d       = '0;
        state_d     = srws_pkg::ST_WADDR;
      end
      srws_pkg::ST_WADDR: begin
        if (pend_q) begin
          n_d   = n_q + 1'b1;
          sx_d  = sx_q + SXW'(elapsed_q);
          sy_d  = sy_q + SYW'(py_q);
          sxx_d = sxx_q + SXXW'(xx);
          sxy_d = sxy_q + SXYW'(xy);
        end
        pend_d = 1'b0;
        if (k_q == '0) begin
          state_d = srws_pkg::ST_MUL1;
        end else begin
          ram_raddr = srws_pkg::slot_of(wp_q, CW'(k_q - 1'b1));
          k_d       = k_q - 1'b1;
          state_d   = srws_pkg::ST_WDATA;
        end
      end
      srws_pkg::ST_WDATA: begin
        state_d = srws_pkg::ST_WADDR;
        if (rd_time >= wstart_q) begin
          if (got_first_q && (gap > 32'(cfg_i.max_gap_seconds))) begin
            state_d = srws_pkg::ST_DONE;
          end else begin
            elapsed_d   = got_first_q ? elapsed_q + XW'(gap) : elapsed_q;
            prev_d      = rd_time;
            got_first_d = 1'b1;
            pend_d      = (code != cfg_i.detached_code) && (code != cfg_i.invalid_code);
            py_d        = $signed(code);
          end
        end
      end
      srws_pkg::ST_MUL1: begin
        p1_d    = n_q * sxx_q;
        p2_d    = sx_q * sx_q;
        state_d = srws_pkg::ST_MUL2;
      end
      srws_pkg::ST_MUL2: begin
        p3_d    = $signed({1'b0, n_q}) * sxy_q;
        p4_d    = $signed({1'b0, sx_q}) * sy_q;
        state_d = srws_pkg::ST_SUB;
      end
      srws_pkg::ST_SUB: begin
        den_d = $signed({1'b0, p1_q}) - $signed({1'b0, p2_q});
        num_d = p3_q - p4_q;
        if ((32'(n_q) < 32'(cfg_i.min_points)) || (den_d <= 0)) begin
          state_d = srws_pkg::ST_DONE;
        end else begin
          state_d = srws_pkg::ST_ABS;
        end
      end
      srws_pkg::ST_ABS: begin
        neg_d   = num_q[NUMW-1];
        mag_d   = num_q[NUMW-1] ? MAGW'(-num_q) : MAGW'(num_q);
        state_d = srws_pkg::ST_SCALE;
      end
      srws_pkg::ST_SCALE: begin
        dvd_d   = mag_q * srws_pkg::SLOPE_SCALE;
        rem_d   = '0;
        quo_d   = '0;
        dcnt_d  = DCW'(DVW);
        state_d = srws_pkg::ST_DIV;
      end
      srws_pkg::ST_DIV: begin
        dvd_d = {dvd_q[DVW-2:0], 1'b0};
        if (sh >= {1'b0, den_q[RW-1:0]}) begin
          rem_d = RW'(sh - {1'b0, den_q[RW-1:0]});
          quo_d = {quo_q[DVW-2:0], 1'b1};
        end else begin
          rem_d = sh[RW-1:0];
          quo_d = {quo_q[DVW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          state_d = srws_pkg::ST_FIN;
        end
      end
      srws_pkg::ST_FIN: begin
        res_d.ok = 1'b1;
        if (neg_q) begin
          res_d.slope = (quo_q >= DVW'(64'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q_lo);
        end else begin
          res_d.slope = (quo_q > DVW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_lo;
        end
        state_d = srws_pkg::ST_DONE;
      end
      srws_pkg::ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          out_d              = res_q;
          out_d.stored_count = 7'(held_q);
          out_valid_d        = 1'b1;
          state_d            = srws_pkg::ST_IDLE;
        end
      end
      default: state_d = srws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srws_pkg::ST_IDLE;
      wp_q        <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    probe_q     <= probe_d;
    wstart_q    <= wstart_d;
    prev_q      <= prev_d;
    got_first_q <= got_first_d;
    elapsed_q   <= elapsed_d;
    pend_q      <= pend_d;
    py_q        <= py_d;
    n_q         <= n_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    sxx_q       <= sxx_d;
    sxy_q       <= sxy_d;
    p1_q        <= p1_d;
    p2_q        <= p2_d;
    p3_q        <= p3_d;
    p4_q        <= p4_d;
    den_q       <= den_d;
    num_q       <= num_d;
    neg_q       <= neg_d;
    mag_q       <= mag_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dcnt_q      <= dcnt_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign res_o      = out_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(srws_pkg::RING_DEPTH))
    else $error("ring count beyond depth");

  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == srws_pkg::ST_WDATA |=>
      (state_q == srws_pkg::ST_WADDR || state_q == srws_pkg::ST_DONE))
    else $error("walk left its loop unexpectedly");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srws_pkg::ST_DONE && (!m_tvalid_o || m_tready_i)) |=> m_tvalid_o)
    else $error("finished word not presented");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == srws_pkg::ST_IDLE && head_i.valid))
    else $error("queue popped outside idle");

endmodule

// ===== rtl/sample_ring_with_window_slope_top.sv =====
// Sample ring with least-squares window slope.
// Commands enter on the slave stream: tuser carries the opcode (push, read
// by age, slope, clear) and tdata the sample time, four probe codes, the
// probe select and the age index. Every command gives exactly one word on
// the master stream: tuser carries the ok flag, tdata the read time, the
// four read codes, the slope and the ring count after the command.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must do so only while no command is in flight, as the block does not enforce it.
// A push, clear or rejected read passes the result register into the output
// register; a valid read first fetches its word from the ring. A slope walks
// up to min(count, 20) entries on the single ring read port, then runs set-up,
// products, sign, the bit-serial divider and the result; a void slope ends
// earlier. A new command is taken only after the last word is presented.
// A two-word command queue lets the sender run ahead of the executing
// engine; when the receiver stalls, the finished word stays in the output
// register, the engine waits and the queue fills, then tready falls.
// Reset empties the ring and the queue and restores the register defaults.
module sample_ring_with_window_slope_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sample_time, temp_a, temp_b, temp_c, temp_d, probe_select, age_index
  input  logic [103:0] s_axis_tdata_i,
  // opcode
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // read_time, read_temp_a, read_temp_b, read_temp_c, read_temp_d, slope,
  // stored_count, zero pad
  output logic [135:0] m_axis_tdata_o,
  // ok
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  srws_pkg::cfg_t    cfg_q, cfg_d;
  srws_pkg::q_head_t head;
  srws_pkg::res_t    res;
  logic              pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (srws_pkg::cfg_idx_e'(cfg_index_i))
        srws_pkg::CFG_DETACHED:   cfg_d.detached_code   = cfg_data_i;
        srws_pkg::CFG_INVALID:    cfg_d.invalid_code    = cfg_data_i;
        srws_pkg::CFG_WINDOW:     cfg_d.window_seconds  = cfg_data_i;
        srws_pkg::CFG_MAX_GAP:    cfg_d.max_gap_seconds = cfg_data_i;
        srws_pkg::CFG_MIN_POINTS: cfg_d.min_points      = cfg_data_i[4:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detached_code   <= 16'h8000;
      cfg_q.invalid_code    <= 16'h8001;
      cfg_q.window_seconds  <= 16'd600;
      cfg_q.max_gap_seconds <= 16'd120;
      cfg_q.min_points      <= 5'd12;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  srws_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .head_o         (head),
    .pop_i          (pop)
  );

  srws_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .cfg_i     (cfg_q),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tready_i(m_axis_tready_i),
    .res_o     (res)
  );

  assign m_axis_tdata_o = {1'b0, res.stored_count, res.slope, res.temps, res.read_time};
  assign m_axis_tuser_o = res.ok;

endmodule
